// ===== rtl/csvfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package csvfp_pkg;

  // Field buffer geometry
  localparam int FIELD_DEPTH = 64;
  localparam int LEN_W       = $clog2(FIELD_DEPTH + 1);
  localparam int ADDR_W      = $clog2(FIELD_DEPTH);
  localparam int CHAR_W      = 16;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_QUOTE = 16'h0022;
  localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;
  localparam logic [CHAR_W-1:0] CH_LF    = 16'h000A;
  localparam logic [CHAR_W-1:0] CH_TAB   = 16'h0009;

  // Configuration register indexes
  localparam logic CFG_SEPARATOR  = 1'b0;
  localparam logic CFG_SWAP_BYTES = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // take the input request and update the parser state
    logic rd_en;   // read the field buffer at the replay pointer
    logic step;    // retire the character just read
    logic flush;   // send the closing result of the field
  } csvfp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic emit_req;   // the presented request ends a field
    logic has_chars;  // the ending field has characters to replay
    logic keep;       // the character just read is kept
    logic hold_v;     // a kept character waits in the hold register
    logic more;       // more characters follow in the replay
    logic out_free;   // the output register can load this cycle
  } csvfp_status_t;

endpackage

`default_nettype wire

// ===== rtl/csvfp_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csvfp_datapath (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire csvfp_pkg::csvfp_cmd_t   cmd,
  output csvfp_pkg::csvfp_status_t     st,
  input  wire                          in_kind,
  input  wire [csvfp_pkg::CHAR_W-1:0]  in_char_code,
  input  wire                          cfg_we,
  input  wire                          cfg_index,
  input  wire [csvfp_pkg::CHAR_W-1:0]  cfg_data,
  input  wire                          out_ready,
  output logic                         out_valid,
  output logic [csvfp_pkg::CHAR_W-1:0] out_char_value,
  output logic                         out_char_valid,
  output logic                         out_field_end,
  output logic                         out_row_end,
  output logic                         out_overflow,
  output logic                         out_last
);

  localparam int LW = csvfp_pkg::LEN_W;
  localparam int AW = csvfp_pkg::ADDR_W;
  localparam int CW = csvfp_pkg::CHAR_W;

  // Configuration registers
  logic [CW-1:0] sep_r;
  logic          swap_r;

  // Parser state
  logic          parity_r, parity_nxt;
  logic          skip_lf_r, skip_lf_nxt;
  logic          line_started_r, line_started_nxt;
  logic          any_row_r, any_row_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          trunc_r, trunc_nxt;
  logic          first_q_r, last_q_r;

  // Field buffer
  logic [CW-1:0] store_mem [csvfp_pkg::FIELD_DEPTH];

  // Replay state
  logic [LW-1:0] rd_ptr_r;
  logic [LW-1:0] stop_r;
  logic          quoted_r, rend_r, ovf_r, drop_r;
  logic [CW-1:0] rdata_r;
  logic [CW-1:0] hold_r;
  logic          hold_v_r;

  // Output register
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] out_char_r, out_char_nxt;
  logic          out_cvalid_r, out_cvalid_nxt;
  logic          out_fend_r, out_fend_nxt;
  logic          out_rend_r, out_rend_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  // Classification of the incoming character
  logic [CW-1:0] ch;
  logic          is_lf, is_cr, is_q, is_sep;
  logic          do_append, do_emit, emit_rend, full;
  logic          quoted;
  logic [LW-1:0] start_ptr, stop_val;
  logic          rd_is_q, keep, push, load_out;

  assign ch     = swap_r ? {in_char_code[7:0], in_char_code[15:8]} : in_char_code;
  assign is_lf  = (ch == csvfp_pkg::CH_LF);
  assign is_cr  = (ch == csvfp_pkg::CH_CR);
  assign is_q   = (ch == csvfp_pkg::CH_QUOTE);
  assign is_sep = (ch == sep_r);
  assign full   = (len_r == LW'(csvfp_pkg::FIELD_DEPTH));

  // Decide the parser action for the presented request
  always_comb begin
    parity_nxt       = parity_r;
    skip_lf_nxt      = skip_lf_r;
    line_started_nxt = line_started_r;
    any_row_nxt      = any_row_r;
    do_append        = 1'b0;
    do_emit          = 1'b0;
    emit_rend        = 1'b0;
    if (in_kind) begin
      // End of input: flush the open row, then return to reset state
      do_emit          = line_started_r | any_row_r;
      emit_rend        = 1'b1;
      parity_nxt       = 1'b0;
      skip_lf_nxt      = 1'b0;
      line_started_nxt = 1'b0;
      any_row_nxt      = 1'b0;
    end else if (skip_lf_r && is_lf) begin
      // Drop the LF of a CR LF pair
      skip_lf_nxt = 1'b0;
    end else begin
      skip_lf_nxt = 1'b0;
      if (is_lf || is_cr) begin
        if (parity_r) begin
          do_append        = 1'b1;
          line_started_nxt = 1'b1;
        end else begin
          do_emit          = 1'b1;
          emit_rend        = 1'b1;
          any_row_nxt      = 1'b1;
          line_started_nxt = 1'b0;
          skip_lf_nxt      = is_cr;
        end
      end else begin
        line_started_nxt = 1'b1;
        if (is_q) begin
          parity_nxt = ~parity_r;
          do_append  = 1'b1;
        end else if (is_sep && !parity_r) begin
          do_emit = 1'b1;
        end else begin
          do_append = 1'b1;
        end
      end
    end

    // Field length and truncation flag
    len_nxt   = len_r;
    trunc_nxt = trunc_r;
    if (do_emit || in_kind) begin
      len_nxt   = '0;
      trunc_nxt = 1'b0;
    end else if (do_append) begin
      if (full) begin
        trunc_nxt = 1'b1;
      end else begin
        len_nxt = len_r + LW'(1);
      end
    end
  end

  // Replay bounds of the field that ends now
  assign quoted    = (len_r > LW'(1)) && first_q_r && last_q_r;
  assign start_ptr = quoted ? LW'(1) : '0;
  assign stop_val  = quoted ? (len_r - LW'(1)) : len_r;

  // Collapse doubled quotes: keep the first, drop the second
  assign rd_is_q  = (rdata_r == csvfp_pkg::CH_QUOTE);
  assign keep     = !(quoted_r && drop_r && rd_is_q);
  assign push     = cmd.step && keep && hold_v_r;
  assign load_out = push || cmd.flush;

  assign st.emit_req  = do_emit;
  assign st.has_chars = (start_ptr < stop_val);
  assign st.keep      = keep;
  assign st.hold_v    = hold_v_r;
  assign st.more      = ((rd_ptr_r + LW'(1)) < stop_r);
  assign st.out_free  = !out_valid_r || out_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r  <= csvfp_pkg::CH_TAB;
      swap_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csvfp_pkg::CFG_SEPARATOR:  sep_r  <= cfg_data;
        csvfp_pkg::CFG_SWAP_BYTES: swap_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Parser state update on an accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r       <= 1'b0;
      skip_lf_r      <= 1'b0;
      line_started_r <= 1'b0;
      any_row_r      <= 1'b0;
      len_r          <= '0;
      trunc_r        <= 1'b0;
      first_q_r      <= 1'b0;
      last_q_r       <= 1'b0;
    end else if (cmd.accept) begin
      parity_r       <= parity_nxt;
      skip_lf_r      <= skip_lf_nxt;
      line_started_r <= line_started_nxt;
      any_row_r      <= any_row_nxt;
      len_r          <= len_nxt;
      trunc_r        <= trunc_nxt;
      if (do_append && !full) begin
        if (len_r == '0) begin
          first_q_r <= is_q;
        end
        last_q_r <= is_q;
      end
    end
  end

  // Field buffer write and registered read
  always_ff @(posedge clk) begin
    if (cmd.accept && do_append && !full) begin
      store_mem[len_r[AW-1:0]] <= ch;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= store_mem[rd_ptr_r[AW-1:0]];
    end
  end

  // Replay control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      drop_r   <= 1'b0;
      rd_ptr_r <= '0;
      stop_r   <= '0;
      quoted_r <= 1'b0;
      rend_r   <= 1'b0;
      ovf_r    <= 1'b0;
    end else if (cmd.accept && do_emit) begin
      // Snapshot the ending field
      hold_v_r <= 1'b0;
      drop_r   <= 1'b0;
      rd_ptr_r <= start_ptr;
      stop_r   <= stop_val;
      quoted_r <= quoted;
      rend_r   <= emit_rend;
      ovf_r    <= trunc_r;
    end else if (cmd.step) begin
      rd_ptr_r <= rd_ptr_r + LW'(1);
      drop_r   <= quoted_r && rd_is_q && !drop_r;
      if (keep) begin
        hold_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && keep) begin
      hold_r <= rdata_r;
    end
  end

  // Output register: load from hold on push or flush, drop when taken
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_char_nxt   = out_char_r;
    out_cvalid_nxt = out_cvalid_r;
    out_fend_nxt   = out_fend_r;
    out_rend_nxt   = out_rend_r;
    out_ovf_nxt    = out_ovf_r;
    if (load_out) begin
      out_valid_nxt  = 1'b1;
      out_char_nxt   = hold_v_r ? hold_r : '0;
      out_cvalid_nxt = hold_v_r;
      out_fend_nxt   = cmd.flush;
      out_rend_nxt   = rend_r;
      out_ovf_nxt    = ovf_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r   <= out_char_nxt;
    out_cvalid_r <= out_cvalid_nxt;
    out_fend_r   <= out_fend_nxt;
    out_rend_r   <= out_rend_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_char_value = out_char_r;
  assign out_char_valid = out_cvalid_r;
  assign out_field_end  = out_fend_r;
  assign out_row_end    = out_rend_r;
  assign out_overflow   = out_ovf_r;
  // One field at most per request, so its closing result is the last one
  assign out_last       = out_fend_r;

endmodule

`default_nettype wire

// ===== rtl/csvfp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csvfp_ctrl (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire csvfp_pkg::csvfp_status_t st,
  output csvfp_pkg::csvfp_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_PROC  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Sequence the parse and the replay of an ending field
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (st.emit_req) begin
            state_nxt = st.has_chars ? S_READ : S_FLUSH;
          end
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_PROC;
      end
      S_PROC: begin
        // Hold while a kept character cannot push the pending one out
        if (!(st.keep && st.hold_v && !st.out_free)) begin
          cmd.step  = 1'b1;
          state_nxt = st.more ? S_READ : S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (st.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/csv_field_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    in_kind, in_char_code
// out      output     out_valid/out_ready  out_char_value, out_char_valid, out_field_end,
//                                          out_row_end, out_overflow, out_last
// cfg      input      cfg_we               cfg_index, cfg_data
//
// A request that does not end a field is taken in idle, and the block stays ready. A
// request that ends a field is followed by a replay of its buffer entries, each a
// registered read and then a retire (the outer quotes of a quoted field are not read),
// then by the closing result. Reset (synchronous, rst_n low) clears the parser and sets
// separator to TAB. A stalled output register stalls the replay; no request is
// taken during replay.

module csv_field_parser (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_kind,
  input  wire [csvfp_pkg::CHAR_W-1:0]  in_char_code,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [csvfp_pkg::CHAR_W-1:0] out_char_value,
  output logic                         out_char_valid,
  output logic                         out_field_end,
  output logic                         out_row_end,
  output logic                         out_overflow,
  output logic                         out_last,
  input  wire                          cfg_we,
  input  wire                          cfg_index,
  input  wire [csvfp_pkg::CHAR_W-1:0]  cfg_data
);

  csvfp_pkg::csvfp_cmd_t    cmd;
  csvfp_pkg::csvfp_status_t st;

  csvfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  csvfp_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_kind        (in_kind),
    .in_char_code   (in_char_code),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_char_value (out_char_value),
    .out_char_valid (out_char_valid),
    .out_field_end  (out_field_end),
    .out_row_end    (out_row_end),
    .out_overflow   (out_overflow),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

// ===== tb/tb_csv_field_parser.sv =====
`timescale 1ns / 1ps

module tb_csv_field_parser;

  localparam int CHAR_W      = csvfp_pkg::CHAR_W;
  localparam int FIELD_DEPTH = csvfp_pkg::FIELD_DEPTH;
  localparam logic [CHAR_W-1:0] CH_QUOTE = csvfp_pkg::CH_QUOTE;
  localparam logic [CHAR_W-1:0] CH_CR    = csvfp_pkg::CH_CR;
  localparam logic [CHAR_W-1:0] CH_LF    = csvfp_pkg::CH_LF;
  localparam logic [CHAR_W-1:0] CH_TAB   = csvfp_pkg::CH_TAB;
  localparam logic CFG_SEPARATOR  = csvfp_pkg::CFG_SEPARATOR;
  localparam logic CFG_SWAP_BYTES = csvfp_pkg::CFG_SWAP_BYTES;

  localparam int STALL_LIMIT = 3000;
  localparam int PHASE_REQUESTS = 8;
  localparam int NUM_PHASES = 6;
  localparam int SETTLE_CYCLES = 10;

  // One replayed character as it leaves the block
  typedef struct packed {
    logic [CHAR_W-1:0] value;
    logic              valid;
    logic              field_end;
    logic              row_end;
    logic              overflow;
    logic              last;
  } field_char_t;

  // Tracks quote parity, row state and the field buffer; queues replayed characters
  class csv_field_tracker;
    logic [CHAR_W-1:0] separator;
    bit                swap_bytes;
    bit                in_quotes;
    bit                drop_lf;
    bit                line_open;
    bit                row_closed;
    logic [CHAR_W-1:0] field_buf [FIELD_DEPTH];
    int unsigned       field_len;
    bit                truncated;
    field_char_t       due_chars [$];
    int                errors;
    int                chars_checked;
    int                fields_seen;
    int                clipped_fields;

    function new();
      separator = CH_TAB;
      swap_bytes = 1'b0;
      errors = 0;
      chars_checked = 0;
      fields_seen = 0;
      clipped_fields = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      in_quotes = 1'b0;
      drop_lf = 1'b0;
      line_open = 1'b0;
      row_closed = 1'b0;
      field_len = 0;
      truncated = 1'b0;
    endfunction

    function void set_register(logic index, logic [CHAR_W-1:0] data);
      if (index == CFG_SEPARATOR) begin
        separator = data;
      end else begin
        swap_bytes = data[0];
      end
    endfunction

    // Append to the field buffer, or flag the field once the buffer is full
    function void store_char(logic [CHAR_W-1:0] c);
      if (field_len < FIELD_DEPTH) begin
        field_buf[field_len] = c;
        field_len++;
      end else begin
        truncated = 1'b1;
      end
    endfunction

    function void queue_char(logic [CHAR_W-1:0] value, bit valid, bit closes_row);
      field_char_t r;
      r.value = value;
      r.valid = valid;
      r.field_end = !valid;
      r.row_end = closes_row;
      r.overflow = truncated;
      r.last = !valid;
      due_chars.insert(due_chars.size(), r);
    endfunction

    // Replay the buffered field, unquoting it when it is wrapped in quotes
    function void replay_field(bit closes_row);
      int unsigned count;
      int unsigned i;
      int unsigned stop;
      field_char_t tail;
      count = 0;
      if (field_len > 1 && field_buf[0] == CH_QUOTE && field_buf[field_len-1] == CH_QUOTE) begin
        stop = field_len - 1;
        i = 1;
        while (i < stop) begin
          // collapse a doubled quote to one
          if (field_buf[i] == CH_QUOTE && i + 1 < stop && field_buf[i+1] == CH_QUOTE) begin
            i++;
          end
          queue_char(field_buf[i], 1'b1, closes_row);
          count++;
          i++;
        end
      end else begin
        for (i = 0; i < field_len; i++) begin
          queue_char(field_buf[i], 1'b1, closes_row);
          count++;
        end
      end
      if (count == 0) begin
        queue_char('0, 1'b0, closes_row);
      end else begin
        tail = due_chars[due_chars.size() - 1];
        tail.field_end = 1'b1;
        tail.last = 1'b1;
        due_chars[due_chars.size() - 1] = tail;
      end
      fields_seen++;
      if (truncated) begin
        clipped_fields++;
      end
      field_len = 0;
      truncated = 1'b0;
    endfunction

    // Advance the parser by one accepted request
    function void note_request(bit kind, logic [CHAR_W-1:0] code);
      logic [CHAR_W-1:0] c;
      if (kind) begin
        if (line_open || row_closed) begin
          replay_field(1'b1);
        end
        clear_parser();
        return;
      end
      c = swap_bytes ? {code[7:0], code[15:8]} : code;
      if (drop_lf) begin
        drop_lf = 1'b0;
        if (c == CH_LF) begin
          return;
        end
      end
      if (c == CH_LF || c == CH_CR) begin
        if (in_quotes) begin
          store_char(c);
          line_open = 1'b1;
        end else begin
          replay_field(1'b1);
          row_closed = 1'b1;
          line_open = 1'b0;
          drop_lf = (c == CH_CR);
        end
        return;
      end
      line_open = 1'b1;
      if (c == CH_QUOTE) begin
        in_quotes = !in_quotes;
        store_char(c);
      end else if (c == separator && !in_quotes) begin
        replay_field(1'b0);
      end else begin
        store_char(c);
      end
    endfunction

    function void compare_field(string name, logic [CHAR_W-1:0] want, logic [CHAR_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(field_char_t got);
      field_char_t want;
      if (due_chars.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = due_chars.pop_front();
      chars_checked++;
      compare_field("char_value", want.value, got.value);
      compare_field("char_valid", CHAR_W'(want.valid), CHAR_W'(got.valid));
      compare_field("field_end", CHAR_W'(want.field_end), CHAR_W'(got.field_end));
      compare_field("row_end", CHAR_W'(want.row_end), CHAR_W'(got.row_end));
      compare_field("overflow", CHAR_W'(want.overflow), CHAR_W'(got.overflow));
      compare_field("last", CHAR_W'(want.last), CHAR_W'(got.last));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic              in_kind;
  logic [CHAR_W-1:0] in_char_code;
  logic              out_valid;
  logic              out_ready;
  logic [CHAR_W-1:0] out_char_value;
  logic              out_char_valid;
  logic              out_field_end;
  logic              out_row_end;
  logic              out_overflow;
  logic              out_last;
  logic              cfg_we;
  logic              cfg_index;
  logic [CHAR_W-1:0] cfg_data;

  csv_field_tracker  tracker;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  logic [CHAR_W-1:0] cur_sep = CH_TAB;
  bit                cur_swap = 1'b0;
  bit                want_long = 1'b0;
  int                requests_sent = 0;
  int                phase_requests = 0;
  int                idle_cycles = 0;

  csv_field_parser uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_char_code   (in_char_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_value (out_char_value),
    .out_char_valid (out_char_valid),
    .out_field_end  (out_field_end),
    .out_row_end    (out_row_end),
    .out_overflow   (out_overflow),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #6 clk = ~clk;

  // Check each accepted result and stall the output at random
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_result(field_char_t'({out_char_value, out_char_valid, out_field_end,
                                          out_row_end, out_overflow, out_last}));
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // End the run when no request moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one request, hold it until taken, then idle at random
  task automatic send_request(input bit kind, input logic [CHAR_W-1:0] code);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_char_code <= code;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    tracker.note_request(kind, code);
    requests_sent++;
    phase_requests++;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Send a character as the parser should see it after the byte swap
  task automatic send_char(input logic [CHAR_W-1:0] ch);
    send_request(1'b0, cur_swap ? {ch[7:0], ch[15:8]} : ch);
  endtask

  task automatic send_end();
    send_request(1'b1, CHAR_W'($urandom));
  endtask

  // Drop valid and wait until every expected character has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.due_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [CHAR_W-1:0] sep, input bit swap);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SEPARATOR;
    cfg_data <= sep;
    @(posedge clk);
    tracker.set_register(CFG_SEPARATOR, sep);
    cfg_index <= CFG_SWAP_BYTES;
    cfg_data <= {{(CHAR_W-1){1'b0}}, swap};
    @(posedge clk);
    tracker.set_register(CFG_SWAP_BYTES, {{(CHAR_W-1){1'b0}}, swap});
    cfg_we <= 1'b0;
    cur_sep = sep;
    cur_swap = swap;
  endtask

  // Any code that is neither a quote, a line break nor the separator
  function automatic logic [CHAR_W-1:0] plain_char();
    logic [CHAR_W-1:0] c;
    do begin
      c = CHAR_W'($urandom);
    end while (c == CH_QUOTE || c == CH_CR || c == CH_LF || c == cur_sep);
    return c;
  endfunction

  // Stray characters that break the well-formed structure
  task automatic send_noise();
    int count;
    int k;
    count = $urandom_range(1, 3);
    for (k = 0; k < count; k++) begin
      case ($urandom_range(5))
        0: send_request(1'b0, CHAR_W'($urandom));
        1: send_char(CH_QUOTE);
        2: send_char(CH_CR);
        3: send_char(CH_LF);
        4: send_char(cur_sep);
        default: send_end();
      endcase
    end
  endtask

  // One row of plain, quoted or oversized fields and a random line ending
  task automatic send_row();
    int fields;
    int f;
    int len;
    int j;
    bit quoted;
    fields = $urandom_range(1, 4);
    for (f = 0; f < fields; f++) begin
      if (want_long) begin
        want_long = 1'b0;
        quoted = 1'($urandom_range(1));
        len = $urandom_range(60, 68);
        if (quoted) send_char(CH_QUOTE);
        for (j = 0; j < len; j++) begin
          send_char(plain_char());
        end
        if (quoted) send_char(CH_QUOTE);
      end else if ($urandom_range(99) < 40) begin
        send_char(CH_QUOTE);
        len = $urandom_range(0, 5);
        for (j = 0; j < len; j++) begin
          case ($urandom_range(9))
            6: begin
              send_char(CH_QUOTE);
              send_char(CH_QUOTE);
            end
            7: send_char(cur_sep);
            8: send_char(CH_CR);
            9: send_char(CH_LF);
            default: send_char(plain_char());
          endcase
        end
        send_char(CH_QUOTE);
      end else begin
        len = $urandom_range(0, 5);
        for (j = 0; j < len; j++) begin
          send_char(plain_char());
        end
      end
      if ($urandom_range(99) < 12) send_noise();
      if (f < fields - 1) send_char(cur_sep);
    end
    case ($urandom_range(9))
      0, 1, 2: send_char(CH_LF);
      3, 4, 5: begin
        send_char(CH_CR);
        send_char(CH_LF);
      end
      6, 7: send_char(CH_CR);
      8: ;
      default: send_end();
    endcase
  endtask

  // Field extremes, empty fields, quoting rules and line endings under reset settings
  task automatic run_directed();
    // lowest and highest codes as one-character fields
    send_char(16'h0000);
    send_char(CH_TAB);
    send_char(16'hFFFF);
    send_char(CH_LF);
    // empty field, then CR LF with the LF dropped
    send_char(CH_TAB);
    send_char(CH_CR);
    send_char(CH_LF);
    // quoted field with a separator inside and a doubled quote
    send_char(CH_QUOTE);
    send_char(16'h0061);
    send_char(CH_TAB);
    send_char(CH_QUOTE);
    send_char(CH_QUOTE);
    send_char(16'h0062);
    send_char(CH_QUOTE);
    send_char(CH_CR);
    // quoted line break, then a bare LF ends the row
    send_char(CH_QUOTE);
    send_char(CH_CR);
    send_char(CH_LF);
    send_char(CH_QUOTE);
    send_char(CH_LF);
    // a pair of quotes only unquotes to an empty field
    send_char(CH_QUOTE);
    send_char(CH_QUOTE);
    send_char(CH_TAB);
    // flush the open row, then an end with nothing read
    send_end();
    send_end();
  endtask

  initial begin
    int phase;
    tracker = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= 1'b0;
    in_char_code <= '0;
    out_ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SEPARATOR;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      case (phase)
        1: configure(16'h002C, 1'b1);
        2: configure(16'hFFFF, 1'b0);
        3: configure(16'h0000, 1'b1);
        4: configure(CH_QUOTE, 1'b0);
        5: configure(CH_CR, 1'b1);
        default: ;
      endcase
      if (phase < 2) begin
        send_idle_pct = 31;
        recv_idle_pct = 78;
      end else if (phase < 4) begin
        send_idle_pct = 78;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      want_long = (phase == 1);
      if (phase == 0) run_directed();
      phase_requests = 0;
      while (phase_requests < PHASE_REQUESTS) begin
        send_row();
      end
    end

    settle();
    repeat (2 * FIELD_DEPTH) @(posedge clk);
    $display("Sent %0d requests under %0d register settings; checked %0d characters in %0d fields",
             requests_sent, NUM_PHASES, tracker.chars_checked, tracker.fields_seen);
    $display("Fields truncated at the buffer limit: %0d", tracker.clipped_fields);
    if (tracker.errors == 0 && tracker.due_chars.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
